/* design/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types, register indexes, codes and reset values of the button press
// counter with blink
// ----------------------------------------------------------------------------
package bpc_pkg;

    // configuration register indexes
    localparam int unsigned CfgIndexW = 3;
    localparam logic [CfgIndexW-1:0] CFG_MODE          = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_LED_ON_MS     = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_LED_OFF_MS    = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_SPAN_MS       = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_HOLD_THRESH   = 3'd4;
    localparam logic [CfgIndexW-1:0] CFG_IDLE_WINDOW   = 3'd5;

    localparam int unsigned CfgDataW = 16;

    // session modes
    localparam logic [1:0] MODE_WAIT  = 2'd0;
    localparam logic [1:0] MODE_COUNT = 2'd1;
    localparam logic [1:0] MODE_DELAY = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    // request operations
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // register reset values
    localparam logic [1:0]  RST_MODE        = MODE_WAIT;
    localparam logic [15:0] RST_LED_ON_MS   = 16'd250;
    localparam logic [15:0] RST_LED_OFF_MS  = 16'd250;
    localparam logic [15:0] RST_SPAN_MS     = 16'd1000;
    localparam logic [15:0] RST_HOLD_THRESH = 16'd20;
    localparam logic [15:0] RST_IDLE_WINDOW = 16'd500;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] led_on_ms;
        logic [15:0] led_off_ms;
        logic [15:0] span_ms;
        logic [15:0] hold_threshold_ms;
        logic [15:0] idle_window_ms;
    } t_cfg;

    typedef struct packed {
        logic operation;
        logic button_level;
    } t_item;

    typedef struct packed {
        logic       led_on;
        logic       busy_res;
        logic       done_res;
        logic [7:0] presses;
    } t_res;

endpackage

/* design/bpc_cfg.sv */
// ----------------------------------------------------------------------------
// bpc_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module bpc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bpc_pkg::CfgIndexW-1:0]  i_cfg_index,
    input  logic [bpc_pkg::CfgDataW-1:0]   i_cfg_wdata,
    output bpc_pkg::t_cfg                  o_cfg
);

    bpc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode              <= bpc_pkg::RST_MODE;
            r_cfg.led_on_ms         <= bpc_pkg::RST_LED_ON_MS;
            r_cfg.led_off_ms        <= bpc_pkg::RST_LED_OFF_MS;
            r_cfg.span_ms           <= bpc_pkg::RST_SPAN_MS;
            r_cfg.hold_threshold_ms <= bpc_pkg::RST_HOLD_THRESH;
            r_cfg.idle_window_ms    <= bpc_pkg::RST_IDLE_WINDOW;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bpc_pkg::CFG_MODE:        r_cfg.mode              <= i_cfg_wdata[1:0];
                bpc_pkg::CFG_LED_ON_MS:   r_cfg.led_on_ms         <= i_cfg_wdata;
                bpc_pkg::CFG_LED_OFF_MS:  r_cfg.led_off_ms        <= i_cfg_wdata;
                bpc_pkg::CFG_SPAN_MS:     r_cfg.span_ms           <= i_cfg_wdata;
                bpc_pkg::CFG_HOLD_THRESH: r_cfg.hold_threshold_ms <= i_cfg_wdata;
                bpc_pkg::CFG_IDLE_WINDOW: r_cfg.idle_window_ms    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/bpc_core.sv */
// ----------------------------------------------------------------------------
// bpc_core
// input register and session state; while the result buffer has room, one request is worked per cycle
// ----------------------------------------------------------------------------
module bpc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bpc_pkg::t_cfg  i_cfg,
    input  logic           i_in_valid,
    input  bpc_pkg::t_item i_item,
    output logic           o_in_stall,
    input  logic           i_res_room,
    output logic           o_res_valid,
    output bpc_pkg::t_res  o_res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TIMING,
        PH_RELEASE
    } t_phase;

    logic           r_in_valid;
    bpc_pkg::t_item r_item;
    logic           advance;
    logic           accept;

    t_phase      r_ph,    n_ph;
    logic [15:0] r_rem,   n_rem;
    logic [15:0] r_pos,   n_pos;
    logic [15:0] r_hold,  n_hold;
    logic [7:0]  r_cnt,   n_cnt;
    logic        r_led,   n_led;
    logic [1:0]  r_smode, n_smode;

    logic        done;
    logic [7:0]  result;
    logic        ended;
    logic        blink_en;
    logic [16:0] cycle_len;

    // press total at session end, with a still running hold past the threshold counted and, in wait mode, capped at one
    function automatic logic [7:0] final_count(input logic [15:0] hold,
                                               input logic [7:0]  cnt,
                                               input logic [15:0] thr,
                                               input logic [1:0]  smode);
        logic [7:0] n;
        n = cnt;
        if (hold > thr && n != 8'hFF) n = n + 8'd1;
        if (smode == bpc_pkg::MODE_WAIT) n = (n != 8'd0) ? 8'd1 : 8'd0;
        return n;
    endfunction

    assign advance    = r_in_valid && i_res_room;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !i_res_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        n_ph      = r_ph;
        n_rem     = r_rem;
        n_pos     = r_pos;
        n_hold    = r_hold;
        n_cnt     = r_cnt;
        n_led     = r_led;
        n_smode   = r_smode;
        done      = 1'b0;
        result    = 8'd0;
        ended     = 1'b0;
        blink_en  = 1'b0;
        cycle_len = {1'b0, i_cfg.led_on_ms} + {1'b0, i_cfg.led_off_ms};

        if (r_item.operation == bpc_pkg::OP_START) begin
            if (i_cfg.mode != bpc_pkg::MODE_RSVD) begin
                n_smode = i_cfg.mode;
                n_pos   = 16'd1;
                n_hold  = 16'd0;
                n_cnt   = 8'd0;
                n_led   = 1'b0;
                if (i_cfg.mode == bpc_pkg::MODE_COUNT) begin
                    n_rem = 16'd0;
                    n_ph  = PH_TIMING;
                end else begin
                    n_rem = i_cfg.span_ms;
                    if (i_cfg.span_ms != 16'd0) begin
                        n_ph = PH_TIMING;
                    end else if (i_cfg.mode == bpc_pkg::MODE_WAIT) begin
                        n_ph = PH_RELEASE;
                    end else begin
                        // zero length delay ends on the start itself
                        n_ph = PH_IDLE;
                        done = 1'b1;
                    end
                end
            end
        end else begin
            case (r_ph)
                PH_TIMING: begin
                    // blink position step
                    blink_en = (r_smode == bpc_pkg::MODE_DELAY) ?
                               (i_cfg.led_on_ms != 16'd0) : 1'b1;
                    if (blink_en) begin
                        if (r_pos == 16'd1) begin
                            n_led = 1'b1;
                        end else if (r_pos == i_cfg.led_on_ms) begin
                            n_led = 1'b0;
                        end else if ({1'b0, r_pos} == cycle_len) begin
                            n_pos = 16'd0;
                        end
                    end
                    n_pos = n_pos + 16'd1;

                    // hold tracking
                    if (r_item.button_level) begin
                        if (r_hold != 16'hFFFF) n_hold = r_hold + 16'd1;
                    end else begin
                        if (r_hold > i_cfg.hold_threshold_ms && r_cnt != 8'hFF) begin
                            n_cnt = r_cnt + 8'd1;
                        end
                        n_hold = 16'd0;
                    end

                    case (r_smode)
                        bpc_pkg::MODE_DELAY: begin
                            if (r_rem != 16'd0) n_rem = r_rem - 16'd1;
                            if (n_rem == 16'd0) begin
                                n_led = 1'b0;
                                if (i_cfg.span_ms <= i_cfg.hold_threshold_ms) begin
                                    n_ph   = PH_IDLE;
                                    done   = 1'b1;
                                    result = (n_hold != 16'd0) ? 8'd1 : 8'd0;
                                end else begin
                                    ended = 1'b1;
                                end
                            end
                        end
                        bpc_pkg::MODE_WAIT: begin
                            if (n_cnt != 8'd0) begin
                                ended = 1'b1;
                            end else begin
                                if (r_rem != 16'd0) n_rem = r_rem - 16'd1;
                                if (n_rem == 16'd0) ended = 1'b1;
                            end
                        end
                        default: begin
                            // idle window restarts on every held tick
                            if (n_hold != 16'd0) begin
                                n_rem = (i_cfg.idle_window_ms != 16'd0) ?
                                        i_cfg.idle_window_ms - 16'd1 : 16'd0;
                            end else if (r_rem != 16'd0) begin
                                n_rem = r_rem - 16'd1;
                            end
                            if (n_cnt != 8'd0 && n_rem == 16'd0) ended = 1'b1;
                        end
                    endcase

                    if (ended) begin
                        n_led = 1'b0;
                        n_ph  = PH_RELEASE;
                    end
                    if (n_ph == PH_RELEASE && !r_item.button_level) begin
                        n_ph   = PH_IDLE;
                        done   = 1'b1;
                        result = final_count(n_hold, n_cnt, i_cfg.hold_threshold_ms,
                                             r_smode);
                    end
                end
                PH_RELEASE: begin
                    if (!r_item.button_level) begin
                        n_ph   = PH_IDLE;
                        done   = 1'b1;
                        result = final_count(r_hold, r_cnt, i_cfg.hold_threshold_ms,
                                             r_smode);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= PH_IDLE;
            r_rem   <= 16'd0;
            r_pos   <= 16'd1;
            r_hold  <= 16'd0;
            r_cnt   <= 8'd0;
            r_led   <= 1'b0;
            r_smode <= bpc_pkg::MODE_WAIT;
        end else if (advance) begin
            r_ph    <= n_ph;
            r_rem   <= n_rem;
            r_pos   <= n_pos;
            r_hold  <= n_hold;
            r_cnt   <= n_cnt;
            r_led   <= n_led;
            r_smode <= n_smode;
        end
    end

    assign o_res_valid    = advance;
    assign o_res.led_on   = n_led;
    assign o_res.busy_res = (n_ph != PH_IDLE);
    assign o_res.done_res = done;
    assign o_res.presses  = done ? result : 8'd0;

endmodule

/* design/bpc_obuf.sv */
// ----------------------------------------------------------------------------
// bpc_obuf
// result register with one skid entry
// ----------------------------------------------------------------------------
module bpc_obuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    input  bpc_pkg::t_res i_wr_res,
    output logic          o_room,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bpc_pkg::t_res o_res
);

    logic          r_head_valid, n_head_valid;
    logic          r_skid_valid, n_skid_valid;
    bpc_pkg::t_res r_head,       n_head;
    bpc_pkg::t_res r_skid,       n_skid;
    logic          pop;

    assign pop = r_head_valid && !i_out_stall;

    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if (pop) begin
            n_head_valid = r_skid_valid;
            n_head       = r_skid;
            n_skid_valid = 1'b0;
        end
        if (i_wr_valid) begin
            if (!n_head_valid) begin
                n_head_valid = 1'b1;
                n_head       = i_wr_res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_wr_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_room      = !r_skid_valid;
    assign o_out_valid = r_head_valid;
    assign o_res       = r_head;

endmodule

/* design/button_press_counter_with_blink.sv */
// ----------------------------------------------------------------------------
// button_press_counter_with_blink
// button press counter session with led blink, one result per request
// ----------------------------------------------------------------------------
// A start request opens a session in the mode held in the mode register (wait
// for one press or a timeout, count presses until an idle window passes, or a
// fixed delay); each tick request stands for one millisecond and carries the
// button level. Every request gives exactly one result: the led level, busy
// while timing or waiting for release, and done with the press count on the
// request that ends the session. A request is taken every cycle while the result
// buffer has room: it sits in the input register, where the session state is
// stepped by a single pass of compares and 16-bit and 8-bit counters, and the result lands
// in an output register backed by one skid entry, so a request passes the input
// register and then the output register, and a stalled result does not block
// the next request. Configuration is written through a plain write port and must
// only change while no session request is in flight; all registers but mode are
// used live, mode is latched at start.
// ----------------------------------------------------------------------------
module button_press_counter_with_blink (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [bpc_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [bpc_pkg::CfgDataW-1:0]  i_cfg_wdata,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic                          i_button_level,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_led_on,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic [7:0]                    o_presses
);

    bpc_pkg::t_cfg  cfg;
    bpc_pkg::t_item item;
    bpc_pkg::t_res  core_res;
    bpc_pkg::t_res  out_res;
    logic           core_res_valid;
    logic           res_room;

    // register file
    bpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign item.operation    = i_operation;
    assign item.button_level = i_button_level;

    // session state, stepped once per request
    bpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .i_item      (item),
        .o_in_stall  (o_in_stall),
        .i_res_room  (res_room),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    // result register, room is from registers only so stall does not
    // ripple back to the request side in the same cycle
    bpc_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_valid  (core_res_valid),
        .i_wr_res    (core_res),
        .o_room      (res_room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    assign o_led_on   = out_res.led_on;
    assign o_busy_res = out_res.busy_res;
    assign o_done_res = out_res.done_res;
    assign o_presses  = out_res.presses;

`ifndef SYNTHESIS
    // a finished session is never still busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("done result reports busy");

    // count only shows on the closing result
    a_presses_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_presses == 8'd0))
        else $error("press count on a result that is not done");

    // the led is always dark once a session has ended
    a_led_dark_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_led_on)
        else $error("led lit on session end");

    // a request only waits while a result is pending on the output side
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("request stalled with no result pending");
`endif

endmodule
